/* rtl/core/brr_pkg.sv */
// Shared types and constants of the bracket balance repair unit.
// Holds the bracket characters, the command codes and the front-to-back
// command item. No dependencies.
package brr_pkg;

    localparam int DEPTH_DEF = 32;
    localparam int Q_DEPTH   = 2;
    localparam int Q_AW      = $clog2(Q_DEPTH);

    localparam logic [7:0] CH_LPAREN = 8'h28;  // (
    localparam logic [7:0] CH_RPAREN = 8'h29;  // )
    localparam logic [7:0] CH_LBRACK = 8'h5B;  // [
    localparam logic [7:0] CH_RBRACK = 8'h5D;  // ]
    localparam logic [7:0] CH_LBRACE = 8'h7B;  // {
    localparam logic [7:0] CH_RBRACE = 8'h7D;  // }

    // bracket kind as stored on the stack
    localparam logic [1:0] BK_PAREN = 2'd0;
    localparam logic [1:0] BK_BRACK = 2'd1;
    localparam logic [1:0] BK_BRACE = 2'd2;

    // command codes from the front part
    localparam logic [1:0] CMD_CHAR  = 2'd0;
    localparam logic [1:0] CMD_OPEN  = 2'd1;
    localparam logic [1:0] CMD_CLOSE = 2'd2;
    localparam logic [1:0] CMD_END   = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] bkind;
        logic [7:0] ch;
    } cmd_t;

endpackage

/* rtl/core/brr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module brr_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/brr_front.sv */
// Front part: accepts input items, classifies each character and queues a
// command for the back part. Depends on brr_pkg.
module brr_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,   // [7:0] char_in
    input  logic          s_tuser,   // [0] op
    output logic          cmd_valid,
    input  logic          cmd_ready,
    output brr_pkg::cmd_t cmd
);
    import brr_pkg::*;

    cmd_t             q_reg [Q_DEPTH];
    logic [Q_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [Q_AW:0]    fill_reg, fill_next;
    cmd_t             cls;
    logic             push, pop;

    always_comb begin
        cls.ch    = s_tdata;
        cls.kind  = CMD_CHAR;
        cls.bkind = BK_PAREN;
        if (s_tuser) begin
            cls.kind = CMD_END;
        end else begin
            unique case (s_tdata)
                CH_LPAREN: begin cls.kind = CMD_OPEN;  cls.bkind = BK_PAREN; end
                CH_LBRACK: begin cls.kind = CMD_OPEN;  cls.bkind = BK_BRACK; end
                CH_LBRACE: begin cls.kind = CMD_OPEN;  cls.bkind = BK_BRACE; end
                CH_RPAREN: begin cls.kind = CMD_CLOSE; cls.bkind = BK_PAREN; end
                CH_RBRACK: begin cls.kind = CMD_CLOSE; cls.bkind = BK_BRACK; end
                CH_RBRACE: begin cls.kind = CMD_CLOSE; cls.bkind = BK_BRACE; end
                default:   cls.kind = CMD_CHAR;
            endcase
        end
    end

    assign s_tready  = (fill_reg != (Q_AW+1)'(Q_DEPTH));
    assign cmd_valid = (fill_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = s_tvalid && s_tready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

/* rtl/core/brr_back.sv */
// Back part: runs queued commands against the bracket stack, keeps the
// repair count and overflow flag, and drives the output register.
// Depends on brr_pkg and brr_ram.
module brr_back #(
    parameter int DEPTH = brr_pkg::DEPTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  brr_pkg::cmd_t cmd,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [31:0]   m_tdata,   // [7:0] char_out, [8] is_balanced,
                                     // [24:9] repair_count, [25] overflow
    output logic          m_tuser,   // [0] is_status
    output logic          m_tlast
);
    import brr_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_POP_RD = 2'd1;
    localparam logic [1:0] ST_POP_EV = 2'd2;
    localparam logic [1:0] ST_STATUS = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] kcnt_reg [3];
    logic [CNT_W-1:0] kcnt_next [3];
    logic [15:0]      rep_reg, rep_next, rep_sat;
    logic             ovf_reg, ovf_next;
    logic             flush_reg, flush_next;
    logic [1:0]       tgt_reg, tgt_next;
    logic [7:0]       ch_reg, ch_next;

    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_ch_reg;
    logic             out_status_reg, out_bal_reg, out_last_reg;
    logic [15:0]      out_rep_reg;
    logic             out_ovf_reg;

    logic             can_emit, emit;
    logic [7:0]       e_ch;
    logic             e_status, e_bal, e_last;
    logic             push_en, pop_en;
    logic [2:0]       kind_live;
    logic [1:0]       rd_kind;
    logic             we;

    function automatic logic [7:0] close_char(input logic [1:0] k);
        logic [7:0] c;
        unique case (k)
            BK_BRACK: c = CH_RBRACK;
            BK_BRACE: c = CH_RBRACE;
            default:  c = CH_RPAREN;
        endcase
        return c;
    endfunction

    brr_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_stack (
        .aclk  (aclk),
        .we    (we),
        .waddr (AW'(cnt_reg)),
        .wdata (cmd.bkind),
        .raddr (AW'(cnt_reg - CNT_W'(1))),
        .rdata (rd_kind)
    );

    assign can_emit = !out_valid_reg || m_tready;
    assign rep_sat  = (rep_reg != 16'hFFFF) ? rep_reg + 16'd1 : rep_reg;
    assign we       = push_en;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            kind_live[i] = (kcnt_reg[i] != '0);
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rep_next   = rep_reg;
        ovf_next   = ovf_reg;
        flush_next = flush_reg;
        tgt_next   = tgt_reg;
        ch_next    = ch_reg;
        cmd_ready  = 1'b0;
        emit       = 1'b0;
        e_ch       = ch_reg;
        e_status   = 1'b0;
        e_bal      = 1'b0;
        e_last     = 1'b0;
        push_en    = 1'b0;
        pop_en     = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                cmd_ready = can_emit;
                if (cmd_valid && can_emit) begin
                    ch_next  = cmd.ch;
                    tgt_next = cmd.bkind;
                    unique case (cmd.kind)
                        CMD_OPEN: begin
                            if (cnt_reg < CNT_W'(DEPTH)) begin
                                push_en  = 1'b1;
                                cnt_next = cnt_reg + 1'b1;
                            end else begin
                                ovf_next = 1'b1;
                            end
                            emit   = 1'b1;
                            e_ch   = cmd.ch;
                            e_last = 1'b1;
                        end
                        CMD_CLOSE: begin
                            if (kind_live[cmd.bkind]) begin
                                // stack top is being read this cycle
                                flush_next = 1'b0;
                                state_next = ST_POP_EV;
                            end else begin
                                rep_next = rep_sat;
                                emit     = 1'b1;
                                e_ch     = cmd.ch;
                                e_last   = 1'b1;
                            end
                        end
                        CMD_END: begin
                            if (cnt_reg != '0) begin
                                flush_next = 1'b1;
                                state_next = ST_POP_EV;
                            end else begin
                                emit     = 1'b1;
                                e_ch     = 8'd0;
                                e_status = 1'b1;
                                e_bal    = (rep_reg == 16'd0);
                                e_last   = 1'b1;
                            end
                        end
                        default: begin
                            emit   = 1'b1;
                            e_ch   = cmd.ch;
                            e_last = 1'b1;
                        end
                    endcase
                end
            end
            ST_POP_RD: begin
                state_next = ST_POP_EV;
            end
            ST_POP_EV: begin
                if (can_emit) begin
                    pop_en   = 1'b1;
                    cnt_next = cnt_reg - 1'b1;
                    emit     = 1'b1;
                    if (!flush_reg && (rd_kind == tgt_reg)) begin
                        // matching opener reached: echo the closer
                        e_ch       = ch_reg;
                        e_last     = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        rep_next = rep_sat;
                        e_ch     = close_char(rd_kind);
                        if (flush_reg && (cnt_reg == CNT_W'(1))) begin
                            state_next = ST_STATUS;
                        end else begin
                            state_next = ST_POP_RD;
                        end
                    end
                end
            end
            default: begin
                if (can_emit) begin
                    emit       = 1'b1;
                    e_ch       = 8'd0;
                    e_status   = 1'b1;
                    e_bal      = (rep_reg == 16'd0);
                    e_last     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // per-kind occupancy counters
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            kcnt_next[i] = kcnt_reg[i];
            if (push_en && (cmd.bkind == 2'(i))) begin
                kcnt_next[i] = kcnt_reg[i] + 1'b1;
            end else if (pop_en && (rd_kind == 2'(i))) begin
                kcnt_next[i] = kcnt_reg[i] - 1'b1;
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            rep_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                kcnt_reg[i] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rep_reg       <= rep_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < 3; i++) begin
                kcnt_reg[i] <= kcnt_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        flush_reg <= flush_next;
        tgt_reg   <= tgt_next;
        ch_reg    <= ch_next;
        if (emit) begin
            out_ch_reg     <= e_ch;
            out_status_reg <= e_status;
            out_bal_reg    <= e_bal;
            out_last_reg   <= e_last;
            out_rep_reg    <= rep_next;
            out_ovf_reg    <= ovf_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_ovf_reg, out_rep_reg, out_bal_reg, out_ch_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

endmodule

/* rtl/core/bracket_balance_repair_unit.sv */
// Bracket balance repair unit: streams characters in and a repaired copy
// out so that the brackets ( [ { balance.
//
// Input channel s_: one item per character (s_tuser low) or an end of
// expression (s_tuser high). Output channel m_: one item per emitted
// character; an end item finishes with a status item (m_tuser high) that
// carries the balance flag. m_tlast marks the last result of each input.
// The repair count and the sticky overflow flag ride on every result.
//
// A result passes through the two-entry command queue and then the
// output register. Ordinary characters and openers are handled in the
// idle state. A closer that unwinds the stack, and an end item that
// flushes it, pop one entry at a time: the stack RAM has a registered
// read and the next top is read after each pop.
// Reset empties the stack and clears the count and flag. When the receiver
// stalls, the output register holds its item, the back part stops, and the
// queue takes up to two more input items before s_tready drops.
// Depends on brr_pkg, brr_front, brr_back and brr_ram.
module bracket_balance_repair_unit #(
    parameter int DEPTH = brr_pkg::DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_in
    input  logic        s_tuser,   // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] char_out, [8] is_balanced,
                                   // [24:9] repair_count, [25] overflow
    output logic        m_tuser,   // [0] is_status
    output logic        m_tlast
);
    import brr_pkg::*;

    cmd_t cmd;
    logic cmd_valid;
    logic cmd_ready;

    brr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    brr_back #(.DEPTH(DEPTH)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
